[rtl/clf_pkg.sv]
// Shared types, constants and tables for the Clifford attractor step block.
// No dependencies; every other file imports this package.
package clf_pkg;

	// Point and coefficient format: signed, VALUE_W bits, FRAC_W fraction bits
	localparam int VALUE_W   = 16;
	localparam int FRAC_W    = 12;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_LANES = 4;

	// Angle product, reduction remainder and phase widths
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int REM_W   = 32;
	localparam int PHASE_W = 16;

	// CORDIC widths: residual phase and vector components (scale 2^30)
	localparam int ZW    = PHASE_W + 1;
	localparam int VEC_W = 32;
	localparam int ACC_W = 48;

	// Sequencing: phase takes reciprocal multiply, back-multiply, correction
	localparam int ITER_W    = 5;
	localparam int DIV_STEPS = 3;
	localparam int ROT_STEPS = 14;
	localparam int RES_SHIFT = 30;

	// One turn in angle units (2^(2*FRAC_W) per radian), and an offset of
	// 11 turns that makes every coef*pos product non-negative
	localparam logic [REM_W-1:0] ANG_MOD = 32'd105414357;
	localparam logic [REM_W-1:0] ANG_OFS = 32'd1159557927;

	// Phase = floor(v*2^16/M) mod 2^16; v*PH_RECIP >> RECIP_SHIFT lands on
	// that quotient or one below it
	localparam int RECIP_SHIFT = 42;
	localparam int QEST_W      = 2 * REM_W - RECIP_SHIFT;
	localparam logic [REM_W-1:0] PH_RECIP =
		REM_W'((64'd1 << (RECIP_SHIFT + PHASE_W)) / 64'(ANG_MOD));

	localparam logic signed [VEC_W-1:0] CORDIC_K  = 32'sd652032874;
	localparam logic signed [ZW-1:0]    QTR_TURN  = 17'sd16384;
	localparam logic signed [ZW-1:0]    HALF_TURN = 17'sd32768;

	localparam int SAT_HI = 2 ** (VALUE_W - 1) - 1;
	localparam int SAT_LO = -(2 ** (VALUE_W - 1));

	// Reset values of the configuration registers
	localparam logic signed [VALUE_W-1:0] COEF_A_RST  = VALUE_W'(-5734);
	localparam logic signed [VALUE_W-1:0] COEF_B_RST  = VALUE_W'(6554);
	localparam logic signed [VALUE_W-1:0] COEF_C_RST  = VALUE_W'(4096);
	localparam logic signed [VALUE_W-1:0] COEF_D_RST  = VALUE_W'(2867);
	localparam logic signed [VALUE_W-1:0] START_X_RST = '0;
	localparam logic signed [VALUE_W-1:0] START_Y_RST = '0;

	typedef enum logic [1:0] {
		REQ_STEP    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_LOAD_X  = 2'd2,
		REQ_LOAD_Y  = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_A  = 3'd0,
		CFG_COEF_B  = 3'd1,
		CFG_COEF_C  = 3'd2,
		CFG_COEF_D  = 3'd3,
		CFG_START_X = 3'd4,
		CFG_START_Y = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_CINIT,
		ST_ROT,
		ST_CMUL,
		ST_UPD
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              emit;
		logic              restart;
		logic              load_x;
		logic              load_y;
		logic              mul;
		logic              prep;
		logic              div;
		logic              cinit;
		logic              rot;
		logic              cmul;
		logic              upd;
		logic [ITER_W-1:0] iter;
	} dp_cmd_t;

	// CORDIC rotation angles, 65536 units per turn
	function automatic logic signed [ZW-1:0] atan_val(input logic [3:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			4'd0:    v = 17'sd8192;
			4'd1:    v = 17'sd4836;
			4'd2:    v = 17'sd2555;
			4'd3:    v = 17'sd1297;
			4'd4:    v = 17'sd651;
			4'd5:    v = 17'sd326;
			4'd6:    v = 17'sd163;
			4'd7:    v = 17'sd81;
			4'd8:    v = 17'sd41;
			4'd9:    v = 17'sd20;
			4'd10:   v = 17'sd10;
			4'd11:   v = 17'sd5;
			4'd12:   v = 17'sd3;
			4'd13:   v = 17'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/clf_if.sv]
// Valid/ready channel interfaces for requests and result points.
// Depends on clf_pkg.
interface clf_req_if;
	import clf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic signed [VALUE_W-1:0] load_value;

	modport source (output valid, output req_type, output load_value, input ready);
	modport sink   (input valid, input req_type, input load_value, output ready);
endinterface

interface clf_res_if;
	import clf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] x_out;
	logic signed [VALUE_W-1:0] y_out;

	modport source (output valid, output x_out, output y_out, input ready);
	modport sink   (input valid, input x_out, input y_out, output ready);
endinterface

[rtl/clf_trig.sv]
// One sine/cosine lane: angle multiply, phase by reciprocal multiplication
// with one correction step, then an iterative 14-step CORDIC. Depends on clf_pkg.
module clf_trig (
	input  logic                              clk,
	input  clf_pkg::dp_cmd_t                  cmd,
	input  logic signed [clf_pkg::VALUE_W-1:0] coef,
	input  logic signed [clf_pkg::VALUE_W-1:0] arg,
	output logic signed [clf_pkg::VEC_W-1:0]   sin_val,
	output logic signed [clf_pkg::VEC_W-1:0]   cos_val
);
	import clf_pkg::*;

	logic signed [PROD_W-1:0]  prod_q;
	logic [REM_W-1:0]          rem_q;
	logic [2*REM_W-1:0]        recip_prod;
	logic [QEST_W-1:0]         qest_q;
	logic [REM_W-1:0]          back_q;
	logic [REM_W-1:0]          resid;
	logic [PHASE_W-1:0]        phase_q;
	logic signed [ZW-1:0]      zx;
	logic signed [ZW-1:0]      z_init;
	logic                      flip_init;
	logic signed [ZW-1:0]      z_q;
	logic                      flip_q;
	logic signed [VEC_W-1:0]   cx_q;
	logic signed [VEC_W-1:0]   cy_q;
	logic signed [VEC_W-1:0]   cx_sh;
	logic signed [VEC_W-1:0]   cy_sh;
	logic [3:0]                rot_idx;
	logic signed [ZW-1:0]      ang;

	// Quotient estimate of v*2^16/M, and what is left of v*2^16 after it
	// (below 2*M, so 32 bits hold it exactly)
	assign recip_prod = (2*REM_W)'(rem_q) * (2*REM_W)'(PH_RECIP);
	assign resid      = {rem_q[REM_W-PHASE_W-1:0], {PHASE_W{1'b0}}} - back_q;

	// Fold the signed phase into a half turn around zero
	always_comb begin
		zx = ZW'($signed(phase_q));
		if (zx > QTR_TURN) begin
			z_init    = zx - HALF_TURN;
			flip_init = 1'b1;
		end else if (zx < -QTR_TURN) begin
			z_init    = zx + HALF_TURN;
			flip_init = 1'b1;
		end else begin
			z_init    = zx;
			flip_init = 1'b0;
		end
	end

	// CORDIC shifts and angle for the current iteration
	assign rot_idx = cmd.iter[3:0];
	assign cx_sh   = cx_q >>> rot_idx;
	assign cy_sh   = cy_q >>> rot_idx;
	assign ang     = atan_val(rot_idx);

	// Lane registers
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= coef * arg;
		end
		if (cmd.prep) begin
			rem_q <= $unsigned(prod_q) + ANG_OFS;
		end
		// Phase: estimate, multiply back, bump by one when a turn is left over
		if (cmd.div) begin
			if (cmd.iter == ITER_W'(0)) begin
				qest_q <= recip_prod[2*REM_W-1:RECIP_SHIFT];
			end else if (cmd.iter == ITER_W'(1)) begin
				back_q <= REM_W'(qest_q) * ANG_MOD;
			end else begin
				phase_q <= qest_q[PHASE_W-1:0] + PHASE_W'(resid >= ANG_MOD);
			end
		end
		if (cmd.cinit) begin
			z_q    <= z_init;
			flip_q <= flip_init;
			cx_q   <= CORDIC_K;
			cy_q   <= '0;
		end
		if (cmd.rot) begin
			if (z_q >= 0) begin
				cx_q <= cx_q - cy_sh;
				cy_q <= cy_q + cx_sh;
				z_q  <= z_q - ang;
			end else begin
				cx_q <= cx_q + cy_sh;
				cy_q <= cy_q - cx_sh;
				z_q  <= z_q + ang;
			end
		end
	end

	assign sin_val = flip_q ? -cy_q : cy_q;
	assign cos_val = flip_q ? -cx_q : cx_q;

endmodule

[rtl/clf_datapath.sv]
// Datapath: configuration registers, the point, the result register,
// four trig lanes and the combine/saturate stage. Depends on clf_pkg, clf_trig.
module clf_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  clf_pkg::dp_cmd_t                   cmd,
	input  logic                               cfg_wr_en,
	input  logic [clf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clf_pkg::VALUE_W-1:0]        cfg_wdata,
	input  logic signed [clf_pkg::VALUE_W-1:0] load_value,
	output logic signed [clf_pkg::VALUE_W-1:0] x_out,
	output logic signed [clf_pkg::VALUE_W-1:0] y_out
);
	import clf_pkg::*;

	logic signed [VALUE_W-1:0] coef_a_q;
	logic signed [VALUE_W-1:0] coef_b_q;
	logic signed [VALUE_W-1:0] coef_c_q;
	logic signed [VALUE_W-1:0] coef_d_q;
	logic signed [VALUE_W-1:0] start_x_q;
	logic signed [VALUE_W-1:0] start_y_q;
	logic signed [VALUE_W-1:0] pos_x_q;
	logic signed [VALUE_W-1:0] pos_y_q;
	logic signed [VALUE_W-1:0] x_out_q;
	logic signed [VALUE_W-1:0] y_out_q;
	logic signed [ACC_W-1:0]   comb_x_q;
	logic signed [ACC_W-1:0]   comb_y_q;

	logic signed [VALUE_W-1:0] lane_coef [NUM_LANES];
	logic signed [VALUE_W-1:0] lane_arg  [NUM_LANES];
	logic signed [VEC_W-1:0]   lane_sin  [NUM_LANES];
	logic signed [VEC_W-1:0]   lane_cos  [NUM_LANES];

	// sin*2^FRAC_W + coef*cos, rounded half up from scale 2^42 to 2^FRAC_W, clamped
	function automatic logic signed [VALUE_W-1:0] term_sat(
		input logic signed [VEC_W-1:0] s,
		input logic signed [ACC_W-1:0] p
	);
		logic signed [ACC_W-1:0]           acc;
		logic signed [ACC_W-RES_SHIFT-1:0] q;
		logic signed [VALUE_W-1:0]         r;
		acc = (ACC_W'(s) <<< FRAC_W) + p + (ACC_W'(1) <<< (RES_SHIFT - 1));
		q   = acc[ACC_W-1:RES_SHIFT];
		if (q > SAT_HI) begin
			r = VALUE_W'(SAT_HI);
		end else if (q < SAT_LO) begin
			r = VALUE_W'(SAT_LO);
		end else begin
			r = q[VALUE_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q  <= COEF_A_RST;
			coef_b_q  <= COEF_B_RST;
			coef_c_q  <= COEF_C_RST;
			coef_d_q  <= COEF_D_RST;
			start_x_q <= START_X_RST;
			start_y_q <= START_Y_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COEF_A:  coef_a_q  <= cfg_wdata;
				CFG_COEF_B:  coef_b_q  <= cfg_wdata;
				CFG_COEF_C:  coef_c_q  <= cfg_wdata;
				CFG_COEF_D:  coef_d_q  <= cfg_wdata;
				CFG_START_X: start_x_q <= cfg_wdata;
				CFG_START_Y: start_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Lane operands: sin(a*y), cos(a*x), sin(b*x), cos(b*y)
	assign lane_coef[0] = coef_a_q;
	assign lane_arg[0]  = pos_y_q;
	assign lane_coef[1] = coef_a_q;
	assign lane_arg[1]  = pos_x_q;
	assign lane_coef[2] = coef_b_q;
	assign lane_arg[2]  = pos_x_q;
	assign lane_coef[3] = coef_b_q;
	assign lane_arg[3]  = pos_y_q;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		clf_trig u_trig (
			.clk     (clk),
			.cmd     (cmd),
			.coef    (lane_coef[i]),
			.arg     (lane_arg[i]),
			.sin_val (lane_sin[i]),
			.cos_val (lane_cos[i])
		);
	end

	// Coefficient times cosine, registered before the final sum
	always_ff @(posedge clk) begin
		if (cmd.cmul) begin
			comb_x_q <= coef_c_q * lane_cos[1];
			comb_y_q <= coef_d_q * lane_cos[3];
		end
	end

	// Result register: the point as it stands when the step is taken
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			x_out_q <= pos_x_q;
			y_out_q <= pos_y_q;
		end
	end

	// Point register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= START_X_RST;
			pos_y_q <= START_Y_RST;
		end else if (cmd.restart) begin
			pos_x_q <= start_x_q;
			pos_y_q <= start_y_q;
		end else if (cmd.load_x) begin
			pos_x_q <= load_value;
		end else if (cmd.load_y) begin
			pos_y_q <= load_value;
		end else if (cmd.upd) begin
			pos_x_q <= term_sat(lane_sin[0], comb_x_q);
			pos_y_q <= term_sat(lane_sin[2], comb_y_q);
		end
	end

	assign x_out = x_out_q;
	assign y_out = y_out_q;

endmodule

[rtl/clf_ctrl.sv]
// Controller: request handshake, result valid flag and the step sequencer
// driving the datapath commands. Depends on clf_pkg.
module clf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       req_type,
	input  logic             out_ready,
	output logic             in_ready,
	output logic             out_valid,
	output clf_pkg::dp_cmd_t cmd
);
	import clf_pkg::*;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              accept;
	logic              last_div;
	logic              last_rot;

	// A request is taken when idle and the result slot is free or draining
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign last_div = iter_q == ITER_W'(DIV_STEPS - 1);
	assign last_rot = iter_q == ITER_W'(ROT_STEPS - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && req_type == REQ_STEP) state_d = ST_MUL;
			ST_MUL:   state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (last_div) state_d = ST_CINIT;
			ST_CINIT: state_d = ST_ROT;
			ST_ROT:   if (last_rot) state_d = ST_CMUL;
			ST_CMUL:  state_d = ST_UPD;
			ST_UPD:   state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		cmd.iter = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.emit    = accept && req_type == REQ_STEP;
				cmd.restart = accept && req_type == REQ_RESTART;
				cmd.load_x  = accept && req_type == REQ_LOAD_X;
				cmd.load_y  = accept && req_type == REQ_LOAD_Y;
			end
			ST_MUL:   cmd.mul   = 1'b1;
			ST_PREP:  cmd.prep  = 1'b1;
			ST_DIV:   cmd.div   = 1'b1;
			ST_CINIT: cmd.cinit = 1'b1;
			ST_ROT:   cmd.rot   = 1'b1;
			ST_CMUL:  cmd.cmul  = 1'b1;
			ST_UPD:   cmd.upd   = 1'b1;
		endcase
	end

	// State, iteration counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= (state_d == state_q) ? iter_q + 1'b1 : '0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/clifford_attractor_step.sv]
// A step request's result (the point before the update) is registered and valid in the cycle after accept.
// A step then occupies the single sequencer through multiply, offset, reciprocal multiply,
// back-multiply and correction for the phase, CORDIC setup, 14 CORDIC iterations,
// coefficient multiply, round and clamp; no new request is taken until it returns to idle.
// Restart and load requests are carried out on accept, keep the sequencer idle and give no result.
// Reset: arst_n low (asynchronous) restores default coefficients, a zero start point and position.
module clifford_attractor_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [clf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clf_pkg::VALUE_W-1:0]   cfg_wdata,
	clf_req_if.sink                       req,
	clf_res_if.source                     res
);
	import clf_pkg::*;

	dp_cmd_t cmd;
	logic    in_ready;
	logic    out_valid;

	clf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.out_ready (res.ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	clf_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.load_value (req.load_value),
		.x_out      (res.x_out),
		.y_out      (res.y_out)
	);

	assign req.ready = in_ready;
	assign res.valid = out_valid;

`ifndef NO_ASSERTIONS
	// A stalled result blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !req.ready)
		else $error("request taken while result stalled");

	// A taken step request shows its result at the next edge
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == REQ_STEP) |=> res.valid)
		else $error("step request without result");

	// Sequencer phases never overlap
	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul, cmd.prep, cmd.div, cmd.cinit, cmd.rot, cmd.cmul, cmd.upd}))
		else $error("overlapping datapath phases");

	// CORDIC iteration index stays within the angle table
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rot |-> (cmd.iter < ITER_W'(ROT_STEPS)))
		else $error("CORDIC iteration out of range");
`endif

endmodule
